FILE: sv/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared constants, types and the arctangent table for the phase CORDIC.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Operand width taken from each input field, and the datapath layout
    localparam int SAMPLE_WIDTH = 32;
    localparam int FIELD_WIDTH  = 32;
    localparam int DATA_WIDTH   = 64;
    localparam int GUARD_BITS   = 60 - SAMPLE_WIDTH;

    // Angle accumulator in units of 2^-16 degree
    localparam int ANGLE_WIDTH  = 26;
    localparam int CORDIC_ITERS = 23;
    localparam int DEG90        = 5898240;

    // Output in units of 2^-7 degree
    localparam int PHASE_WIDTH  = 16;
    localparam int ROUND_SHIFT  = 9;
    localparam int ROUND_HALF   = 256;
    localparam int OUT_MAX      = 23040;
    localparam int OUT_MIN      = -23040;

    // atan(2^-i) in degrees times 65536, rounded
    localparam logic signed [ANGLE_WIDTH-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
        26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
        26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1
    };

    // One vector in flight through the rotation stages
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  x;
        logic signed [DATA_WIDTH-1:0]  y;
        logic signed [ANGLE_WIDTH-1:0] z;
        logic                          imag_zero;
        logic                          real_neg;
    } cpd_vec_t;

endpackage

FILE: sv/cpd_if.sv
// ----------------------------------------------------------------------------
// cpd_in_if / cpd_out_if
// Valid/ready channels for complex input words and phase result words.
// ----------------------------------------------------------------------------
interface cpd_in_if
    import cpd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] real_part;
    logic signed [FIELD_WIDTH-1:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

interface cpd_out_if
    import cpd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [PHASE_WIDTH-1:0] phase_angle;

    modport source (output valid, output phase_angle, input ready);
    modport sink   (input valid, input phase_angle, output ready);
endinterface

FILE: sv/complex_phase_degrees_core.sv
// ----------------------------------------------------------------------------
// complex_phase_degrees_core
// Phase angle of a complex bin, atan2(imag, real), in 1/128 degree units.
// ----------------------------------------------------------------------------
// Usage:
//   sample_in  : valid/ready channel of complex words (real_part, imag_part),
//                signed 32-bit integers.
//   phase_out  : valid/ready channel of result words (phase_angle), signed
//                16-bit, -23040 .. +23040 (-180 .. +180 degrees).
//   Every input word gives exactly one result word, in order.
// Pipeline: 25 register stages (one fold stage, 23 micro-rotation stages,
//   one rounding stage), in that order.
// Throughput: one word per cycle until back-pressure on phase_out fills
//   every stage; each micro-rotation has its own stage, so the pipeline
//   depth alone sets the latency.
// Reset: rst_n clears every stage valid bit; the pipeline comes up empty.
// Stall: a stage holds its word until the stage after it has room, so
//   bubbles close up and sample_in.ready stays high while any stage is free.
//   Nothing is dropped or repeated.
// The block keeps no state between words.
// ----------------------------------------------------------------------------
module complex_phase_degrees_core
    import cpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cpd_in_if.sink    sample_in,
    cpd_out_if.source phase_out
);

    logic     fold_valid;
    logic     fold_ready;
    cpd_vec_t fold_vec;
    logic     rot_valid;
    logic     rot_ready;
    cpd_vec_t rot_vec;

    // quadrant fold
    cpd_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .real_part (sample_in.real_part),
        .imag_part (sample_in.imag_part),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .out_vec   (fold_vec)
    );

    // rotation pipeline
    cpd_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fold_valid),
        .in_ready  (fold_ready),
        .in_vec    (fold_vec),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_vec   (rot_vec)
    );

    // rounding and output register
    cpd_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rot_valid),
        .in_ready    (rot_ready),
        .in_vec      (rot_vec),
        .out_valid   (phase_out.valid),
        .out_ready   (phase_out.ready),
        .phase_angle (phase_out.phase_angle)
    );

    // result always within +-180 degrees
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_out.valid |-> (phase_out.phase_angle <= PHASE_WIDTH'(OUT_MAX)) &&
                            (phase_out.phase_angle >= PHASE_WIDTH'(OUT_MIN)))
        else $error("phase_angle outside +-180 degrees");

    // a ready sink frees every stage, so the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        phase_out.ready |-> sample_in.ready)
        else $error("input stalled while output is ready");

    // a word at the rotation output must be taken when the last stage is free
    a_rot_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rot_valid && !phase_out.valid) |-> rot_ready)
        else $error("rotation output blocked by an empty output register");

    // pipeline comes up empty after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !phase_out.valid)
        else $error("result valid straight after reset");

endmodule

FILE: sv/cpd_prerot.sv
// ----------------------------------------------------------------------------
// cpd_prerot
// Input stage: sign-extends the operands, adds guard bits and turns the
// vector into the right half plane with a starting angle of 0 or +-90 degrees.
// ----------------------------------------------------------------------------
module cpd_prerot
    import cpd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [FIELD_WIDTH-1:0] real_part,
    input  logic signed [FIELD_WIDTH-1:0] imag_part,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cpd_vec_t                      out_vec
);

    logic     valid_reg;
    logic     valid_next;
    cpd_vec_t vec_reg;
    cpd_vec_t vec_next;

    logic signed [DATA_WIDTH-1:0] re_ext;
    logic signed [DATA_WIDTH-1:0] im_ext;
    logic signed [DATA_WIDTH-1:0] x_g;
    logic signed [DATA_WIDTH-1:0] y_g;

    // operand extension and guard bits
    assign re_ext = DATA_WIDTH'($signed(real_part[SAMPLE_WIDTH-1:0]));
    assign im_ext = DATA_WIDTH'($signed(imag_part[SAMPLE_WIDTH-1:0]));
    assign x_g    = re_ext <<< GUARD_BITS;
    assign y_g    = im_ext <<< GUARD_BITS;

    // quadrant fold
    always_comb
    begin
        vec_next.imag_zero = (im_ext == '0);
        vec_next.real_neg  = re_ext[DATA_WIDTH-1];
        if (x_g[DATA_WIDTH-1])
        begin
            if (y_g[DATA_WIDTH-1])
            begin
                vec_next.x = -y_g;
                vec_next.y = x_g;
                vec_next.z = -ANGLE_WIDTH'(DEG90);
            end
            else
            begin
                vec_next.x = y_g;
                vec_next.y = -x_g;
                vec_next.z = ANGLE_WIDTH'(DEG90);
            end
        end
        else
        begin
            vec_next.x = x_g;
            vec_next.y = y_g;
            vec_next.z = '0;
        end
    end

    // stage handshake
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: sv/cpd_cordic.sv
// ----------------------------------------------------------------------------
// cpd_cordic
// Vectoring CORDIC, one registered micro-rotation per stage. Each stage
// holds its word until the next stage has room, so bubbles close up.
// ----------------------------------------------------------------------------
module cpd_cordic
    import cpd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cpd_vec_t in_vec,
    output logic     out_valid,
    input  logic     out_ready,
    output cpd_vec_t out_vec
);

    logic     valid_reg [CORDIC_ITERS];
    cpd_vec_t vec_reg   [CORDIC_ITERS];
    logic     stage_rdy [CORDIC_ITERS+1];

    assign stage_rdy[CORDIC_ITERS] = out_ready;
    assign in_ready                = stage_rdy[0];
    assign out_valid               = valid_reg[CORDIC_ITERS-1];
    assign out_vec                 = vec_reg[CORDIC_ITERS-1];

    for (genvar k = 0; k < CORDIC_ITERS; k++)
    begin : g_stage
        logic     up_valid;
        cpd_vec_t up_vec;
        cpd_vec_t vec_next;
        logic     valid_next;

        logic signed [DATA_WIDTH-1:0] xs;
        logic signed [DATA_WIDTH-1:0] ys;

        if (k == 0)
        begin : g_first
            assign up_valid = in_valid;
            assign up_vec   = in_vec;
        end
        else
        begin : g_rest
            assign up_valid = valid_reg[k-1];
            assign up_vec   = vec_reg[k-1];
        end

        // micro-rotation towards the real axis
        assign xs = up_vec.x >>> k;
        assign ys = up_vec.y >>> k;

        always_comb
        begin
            vec_next = up_vec;
            if (up_vec.y[DATA_WIDTH-1])
            begin
                vec_next.x = up_vec.x - ys;
                vec_next.y = up_vec.y + xs;
                vec_next.z = up_vec.z - ATAN_TAB[k];
            end
            else
            begin
                vec_next.x = up_vec.x + ys;
                vec_next.y = up_vec.y - xs;
                vec_next.z = up_vec.z + ATAN_TAB[k];
            end
        end

        // stage handshake
        assign stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        assign valid_next   = stage_rdy[k] ? up_valid : valid_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_next;
        end

        always_ff @(posedge clk)
        begin
            if (up_valid && stage_rdy[k])
                vec_reg[k] <= vec_next;
        end
    end

endmodule

FILE: sv/cpd_round.sv
// ----------------------------------------------------------------------------
// cpd_round
// Output stage: rounds the angle to 1/128 degree, clamps to +-180 degrees
// and substitutes the exact answer for a zero imaginary part.
// ----------------------------------------------------------------------------
module cpd_round
    import cpd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cpd_vec_t                      in_vec,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [PHASE_WIDTH-1:0] phase_angle
);

    localparam int SUM_WIDTH = ANGLE_WIDTH + 1;
    localparam int RND_WIDTH = SUM_WIDTH - ROUND_SHIFT;

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [PHASE_WIDTH-1:0] phase_reg;
    logic signed [PHASE_WIDTH-1:0] phase_next;

    logic signed [SUM_WIDTH-1:0] z_sum;
    logic signed [SUM_WIDTH-1:0] z_shr;
    logic signed [RND_WIDTH-1:0] z_rnd;

    // round half up, floor shift
    assign z_sum = SUM_WIDTH'(in_vec.z) + SUM_WIDTH'(ROUND_HALF);
    assign z_shr = z_sum >>> ROUND_SHIFT;
    assign z_rnd = z_shr[RND_WIDTH-1:0];

    // clamp, and exact result on the real axis
    always_comb
    begin
        if (in_vec.imag_zero)
            phase_next = in_vec.real_neg ? PHASE_WIDTH'(OUT_MAX) : '0;
        else if (z_rnd > RND_WIDTH'(OUT_MAX))
            phase_next = PHASE_WIDTH'(OUT_MAX);
        else if (z_rnd < RND_WIDTH'(OUT_MIN))
            phase_next = PHASE_WIDTH'(OUT_MIN);
        else
            phase_next = z_rnd[PHASE_WIDTH-1:0];
    end

    // output register handshake
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            phase_reg <= phase_next;
    end

    assign out_valid   = valid_reg;
    assign phase_angle = phase_reg;

endmodule

FILE: sim/cpd_phase_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_phase_checker
// Watches both channels of the phase core, works out the phase of every
// accepted complex word and compares it with the result words in order.
// ----------------------------------------------------------------------------
module cpd_phase_checker
    import cpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cpd_in_if    sample_ch,
    cpd_out_if   phase_ch,
    output int   fail_count,
    output int   pending_words
);

    localparam int PRINT_CAP = 50;

    // atan(2^-i) in degrees, scaled by 65536 and rounded
    localparam longint ARCTAN_DEG [CORDIC_ITERS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1
    };

    logic signed [PHASE_WIDTH-1:0] expected_phase_q[$];
    logic signed [PHASE_WIDTH-1:0] want;

    // Phase of one complex word in 1/128 degree, vectoring CORDIC
    function automatic logic signed [PHASE_WIDTH-1:0] phase_of(
        input logic signed [FIELD_WIDTH-1:0] re,
        input logic signed [FIELD_WIDTH-1:0] im
    );
        longint re_s;
        longint im_s;
        longint x;
        longint y;
        longint nx;
        longint ny;
        longint z;
        longint r;
        re_s = longint'(re);
        im_s = longint'(im);
        // keep the operand bits only, sign-extended
        re_s = (re_s <<< (64 - SAMPLE_WIDTH)) >>> (64 - SAMPLE_WIDTH);
        im_s = (im_s <<< (64 - SAMPLE_WIDTH)) >>> (64 - SAMPLE_WIDTH);
        // on the real axis the answer is exact
        if (im_s == 0)
            return (re_s < 0) ? PHASE_WIDTH'(OUT_MAX) : '0;
        x = re_s <<< GUARD_BITS;
        y = im_s <<< GUARD_BITS;
        z = 0;
        // fold the left half plane over by a quarter turn
        if (x < 0)
        begin
            if (y < 0)
            begin
                nx = -y;
                ny = x;
                z  = -DEG90;
            end
            else
            begin
                nx = y;
                ny = -x;
                z  = DEG90;
            end
            x = nx;
            y = ny;
        end
        // micro-rotations towards the positive real axis
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            if (y < 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ARCTAN_DEG[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ARCTAN_DEG[i];
            end
            x = nx;
            y = ny;
        end
        // round half up to 1/128 degree, then clamp to +-180
        r = (z + ROUND_HALF) >>> ROUND_SHIFT;
        if (r > OUT_MAX)
            r = OUT_MAX;
        if (r < OUT_MIN)
            r = OUT_MIN;
        return PHASE_WIDTH'(r);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= PRINT_CAP)
            $display("%0t ERROR %s", $realtime, msg);
        else if (fail_count == PRINT_CAP + 1)
            $display("%0t ERROR further mismatches counted silently", $realtime);
    endtask

    initial
    begin
        fail_count    = 0;
        pending_words = 0;
    end

    // Input words go into the store first, so a same-edge result still matches
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                expected_phase_q = {expected_phase_q,
                                    phase_of(sample_ch.real_part,
                                             sample_ch.imag_part)};
            if (phase_ch.valid && phase_ch.ready)
            begin
                if (expected_phase_q.size() == 0)
                    report_mismatch($sformatf("result word %0d with nothing expected",
                                              phase_ch.phase_angle));
                else
                begin
                    want = expected_phase_q.pop_front();
                    if (phase_ch.phase_angle !== want)
                        report_mismatch($sformatf("phase_angle got %0d want %0d",
                                                  phase_ch.phase_angle, want));
                end
            end
            pending_words = expected_phase_q.size();
        end
    end

endmodule

FILE: sim/tb_complex_phase_degrees_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_phase_degrees_core
// Drives complex words into the phase core with random gaps on both sides,
// including one long hold-off at the output, and leaves the checking to
// cpd_phase_checker. Directed corner words first, then random ones.
// ----------------------------------------------------------------------------
module tb_complex_phase_degrees_core;
    import cpd_pkg::*;

    localparam int RANDOM_WORDS  = 700;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 250;
    localparam int HOLD_AFTER    = 300;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic signed [FIELD_WIDTH-1:0] FMAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
    localparam logic signed [FIELD_WIDTH-1:0] FMIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_words;
    int   words_sent;
    int   idle_cycles;

    cpd_in_if  in_ch ();
    cpd_out_if out_ch ();

    complex_phase_degrees_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (in_ch),
        .phase_out (out_ch)
    );

    cpd_phase_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_ch     (in_ch),
        .phase_ch      (out_ch),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit busy);
        int roll;
        roll = $urandom_range(0, 99);
        if (busy || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word, with an optional gap before it, until it is taken
    task automatic send_word(input logic signed [FIELD_WIDTH-1:0] re,
                             input logic signed [FIELD_WIDTH-1:0] im,
                             input int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.real_part <= re;
        in_ch.imag_part <= im;
        do
            @(posedge clk);
        while (!in_ch.ready);
        words_sent = words_sent + 1;
    endtask

    // Random operand of random magnitude and sign
    function automatic logic signed [FIELD_WIDTH-1:0] scaled_operand();
        logic signed [FIELD_WIDTH-1:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, FIELD_WIDTH - 1);
    endfunction

    // Random complex word, weighted towards the awkward regions
    task automatic random_word(output logic signed [FIELD_WIDTH-1:0] re,
                               output logic signed [FIELD_WIDTH-1:0] im);
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            re = $urandom;
            im = $urandom;
        end
        else if (kind < 45)
        begin
            re = $signed($urandom_range(0, 32)) - 16;
            im = $signed($urandom_range(0, 32)) - 16;
        end
        else if (kind < 60)
        begin
            // close to the negative real axis, where the result wraps
            re = -$signed($urandom_range(1, 32'h7FFF_FFFF));
            if ($urandom_range(0, 7) == 0)
                re = FMIN;
            im = $signed($urandom_range(0, 6)) - 3;
        end
        else if (kind < 75)
        begin
            if ($urandom_range(0, 1))
            begin
                re = $urandom;
                im = '0;
            end
            else
            begin
                re = '0;
                im = $urandom;
            end
        end
        else
        begin
            re = scaled_operand();
            im = scaled_operand();
        end
    endtask

    // Stimulus: directed corners, then random words
    initial
    begin
        logic signed [FIELD_WIDTH-1:0] re;
        logic signed [FIELD_WIDTH-1:0] im;
        bit busy;
        in_ch.valid     <= 1'b0;
        in_ch.real_part <= '0;
        in_ch.imag_part <= '0;
        words_sent = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, both axes both ways, the extremes and the four quadrants
        send_word('0,   '0,   0);
        send_word(-1,   '0,   0);
        send_word(1,    '0,   0);
        send_word(FMAX, '0,   pick_gap(0));
        send_word(FMIN, '0,   0);
        send_word('0,   FMAX, 0);
        send_word('0,   FMIN, pick_gap(0));
        send_word('0,   1,    0);
        send_word('0,   -1,   0);
        send_word(FMAX, FMAX, 0);
        send_word(FMIN, FMIN, pick_gap(0));
        send_word(FMIN, FMAX, 0);
        send_word(FMAX, FMIN, 0);
        send_word(1,    1,    0);
        send_word(-1,   1,    pick_gap(0));
        send_word(-1,   -1,   0);
        send_word(1,    -1,   0);
        // rounding just either side of +-180 and of zero
        send_word(FMIN, 1,    0);
        send_word(FMIN, -1,   pick_gap(0));
        send_word(-2,   -1,   0);
        send_word(-1000000, 1, 0);
        send_word(-1000000, -1, 0);
        send_word(FMAX, 1,    0);
        send_word(FMAX, -1,   0);

        busy = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
                busy = ($urandom_range(0, 2) == 0);
            random_word(re, im);
            send_word(re, im, pick_gap(busy));
        end
        in_ch.valid <= 1'b0;

        // let the checker count the last word before waiting on the drain
        @(posedge clk);
        wait (pending_words == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("tb_complex_phase_degrees_core passed");
        else
            $display("tb_complex_phase_degrees_core failed");
        $finish;
    end

    // Receiver: random stalls, free stretches, one long hold-off
    initial
    begin
        int stall_left;
        int cycle_no;
        bit held;
        bit free_run;
        out_ch.ready <= 1'b0;
        stall_left = 0;
        cycle_no   = 0;
        held       = 1'b0;
        free_run   = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no = cycle_no + 1;
            if (cycle_no % 200 == 0)
                free_run = ($urandom_range(0, 2) == 0);
            if (!held && words_sent >= HOLD_AFTER)
            begin
                // back-pressure until the core fills and stalls its input
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!free_run && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap(0);
                out_ch.ready <= (stall_left == 0);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no word moving on either channel
    initial
    begin
        idle_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_complex_phase_degrees_core failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: files.f
sv/cpd_pkg.sv
sv/cpd_if.sv
sv/cpd_prerot.sv
sv/cpd_cordic.sv
sv/cpd_round.sv
sv/complex_phase_degrees_core.sv
sim/cpd_phase_checker.sv
sim/tb_complex_phase_degrees_core.sv
